// File: hw/rtl/eehw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eehw_pkg
// Shared types, constants and helper functions of the EBML element header
// walker.
// ----------------------------------------------------------------------------
package eehw_pkg;

  // Deepest nesting of master elements that can be open at once.
  localparam int unsigned MAX_DEPTH   = 8;
  // Width of the running byte offset and of the stored level ends.
  localparam int unsigned OFFSET_BITS = 48;

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_DEPTH);

  localparam int unsigned ID_W   = 64;
  localparam int unsigned SIZE_W = 56;
  localparam int unsigned NEST_W = 4;
  localparam int unsigned PAY_W  = 48;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_LEAD = 2'd1,
    ST_OVERRUN   = 2'd2,
    ST_DEPTH_OVF = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   element_id;
    logic [SIZE_W-1:0] element_size;
    logic [NEST_W-1:0] nest_depth;
    logic [PAY_W-1:0]  payload_offset;
    logic              is_master;
    status_e           status;
  } result_t;

  // Number of zero bits above the first set bit of a vint lead byte.
  function automatic logic [2:0] lead_zeros(input logic [7:0] b);
    logic [2:0] lz;
    lz = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        lz = 3'(7 - i);
      end
    end
    return lz;
  endfunction

  // Master elements whose payload holds child elements.
  function automatic logic is_master_id(input logic [ID_W-1:0] id);
    return (id == 64'h1A45_DFA3) || (id == 64'h1853_8067) ||
           (id == 64'h114D_9B74) || (id == 64'h0000_4DBB) ||
           (id == 64'h1C53_BB6B) || (id == 64'h0000_00BB) ||
           (id == 64'h0000_00B7) || (id == 64'h1654_AE6B);
  endfunction

endpackage

// File: hw/rtl/ebml_element_header_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebml_element_header_walker
// Walks the element headers of an EBML byte stream and reports one event per
// header with ID, size, nesting depth and payload offset.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries the file one byte per
//   transfer, in order from offset zero. The output channel (out_valid_o /
//   out_ready_i) carries one event per element header, or an error event.
//   Every byte is handled in the cycle it is transferred; the event of the
//   byte that completes a header is registered in the output register.
//   One byte per cycle is taken for as long as the receiver keeps up.
//   When the receiver stalls, one further event is held in a skid register
//   and bytes that cause no event keep flowing; in_ready_o drops only while
//   the skid register is occupied.
//   Open levels are kept as a small register file of end offsets, all
//   compared in parallel with the offset at each new header, so any number of
//   levels close in the same cycle.
//   After a zero lead byte, a child overrunning its parent or a depth
//   overflow the error event is sent and later bytes are taken and dropped.
//   Reset clears the walker to the top level at offset zero; the level-end
//   registers need no clearing because only written entries are read.
// ----------------------------------------------------------------------------
module ebml_element_header_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] element_id_o,
  output logic [55:0] element_size_o,
  output logic [3:0]  nest_depth_o,
  output logic [47:0] payload_offset_o,
  output logic        is_master_o,
  output logic [1:0]  status_o
);

  localparam int unsigned OW = eehw_pkg::OFFSET_BITS;
  localparam int unsigned DW = eehw_pkg::DEPTH_W;
  localparam int unsigned IW = eehw_pkg::IDX_W;
  localparam int unsigned MD = eehw_pkg::MAX_DEPTH;

  localparam logic [64:0] OFF_MAX = (65'd1 << OW) - 65'd1;

  localparam logic [1:0] PH_ID   = 2'd0;
  localparam logic [1:0] PH_SIZE = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;

  logic [1:0]                  phase_q, phase_d;
  logic [3:0]                  vrem_q, vrem_d;
  logic [eehw_pkg::ID_W-1:0]   id_q, id_d;
  logic [eehw_pkg::SIZE_W-1:0] size_q, size_d;
  logic [OW-1:0]               offset_q, offset_d;
  logic [eehw_pkg::SIZE_W-1:0] skip_q, skip_d;
  logic [DW-1:0]               depth_q, depth_d;
  logic                        halted_q, halted_d;
  logic [OW-1:0]               level_end_q [MD];

  eehw_pkg::result_t out_q, skid_q, res;
  logic              out_valid_q, skid_valid_q, res_valid;

  logic                        in_fire, out_fire;
  logic [OW-1:0]               off_next;
  logic [2:0]                  lz;
  logic [7:0]                  lead_clr;
  logic [DW-1:0]               depth_pop;
  logic [eehw_pkg::SIZE_W-1:0] size_fin;
  logic [64:0]                 end_sum;
  logic [OW-1:0]               end_val;
  logic [OW-1:0]               parent_end;
  logic                        overrun, master, le_we;
  eehw_pkg::status_e           fin_status;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign off_next = offset_q + OW'(1);
  assign lz       = eehw_pkg::lead_zeros(byte_value_i);
  assign lead_clr = byte_value_i ^ (8'h80 >> lz);

  // Level ends shrink from the outermost level inward, so the levels still
  // open form a prefix and their count is the new depth.
  always_comb begin
    depth_pop = '0;
    for (int i = 0; i < MD; i++) begin
      if ((DW'(i) < depth_q) && (level_end_q[i] > offset_q)) begin
        depth_pop = depth_pop + DW'(1);
      end
    end
  end

  // Header completion: element end, saturated to the offset range.
  assign size_fin   = (vrem_q == 4'd0) ? eehw_pkg::SIZE_W'(lead_clr)
                                       : {size_q[eehw_pkg::SIZE_W-9:0], byte_value_i};
  assign end_sum    = 65'(off_next) + 65'(size_fin);
  assign end_val    = (end_sum > OFF_MAX) ? OW'(OFF_MAX) : end_sum[OW-1:0];
  assign parent_end = level_end_q[IW'(depth_q - DW'(1))];
  assign overrun    = (depth_q != '0) && (end_val > parent_end);
  assign master     = eehw_pkg::is_master_id(id_q);

  always_comb begin
    if (overrun) begin
      fin_status = eehw_pkg::ST_OVERRUN;
    end else if (master && (depth_q >= DW'(MD))) begin
      fin_status = eehw_pkg::ST_DEPTH_OVF;
    end else begin
      fin_status = eehw_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    vrem_d    = vrem_q;
    id_d      = id_q;
    size_d    = size_q;
    offset_d  = offset_q;
    skip_d    = skip_q;
    depth_d   = depth_q;
    halted_d  = halted_q;
    le_we     = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    if (in_fire && !halted_q) begin
      offset_d = off_next;
      case (phase_q)
        PH_SKIP: begin
          if (skip_q != '0) begin
            skip_d = skip_q - eehw_pkg::SIZE_W'(1);
          end
          if (skip_q <= eehw_pkg::SIZE_W'(1)) begin
            phase_d = PH_ID;
          end
        end
        PH_SIZE: begin
          if ((vrem_q == 4'd0) && (byte_value_i == 8'd0)) begin
            res_valid          = 1'b1;
            res.element_id     = id_q;
            res.nest_depth     = eehw_pkg::NEST_W'(depth_q);
            res.payload_offset = eehw_pkg::PAY_W'(off_next);
            res.status         = eehw_pkg::ST_ZERO_LEAD;
            halted_d           = 1'b1;
          end else begin
            size_d = size_fin;
            if (vrem_q == 4'd0) begin
              vrem_d = {1'b0, lz};
            end else begin
              vrem_d = vrem_q - 4'd1;
            end
            if (((vrem_q == 4'd0) && (lz == 3'd0)) || (vrem_q == 4'd1)) begin
              res_valid          = 1'b1;
              res.element_id     = id_q;
              res.element_size   = size_fin;
              res.nest_depth     = eehw_pkg::NEST_W'(depth_q);
              res.payload_offset = eehw_pkg::PAY_W'(off_next);
              res.is_master      = master;
              res.status         = fin_status;
              phase_d            = PH_ID;
              vrem_d             = 4'd0;
              if (fin_status != eehw_pkg::ST_OK) begin
                halted_d = 1'b1;
              end else if (master) begin
                le_we   = 1'b1;
                depth_d = depth_q + DW'(1);
              end else if (size_fin != '0) begin
                skip_d  = size_fin;
                phase_d = PH_SKIP;
              end
            end
          end
        end
        default: begin
          // ID phase; the unused phase code behaves the same way.
          phase_d = PH_ID;
          if (vrem_q == 4'd0) begin
            depth_d = depth_pop;
            if (byte_value_i == 8'd0) begin
              res_valid          = 1'b1;
              res.nest_depth     = eehw_pkg::NEST_W'(depth_pop);
              res.payload_offset = eehw_pkg::PAY_W'(off_next);
              res.status         = eehw_pkg::ST_ZERO_LEAD;
              halted_d           = 1'b1;
            end else begin
              id_d = eehw_pkg::ID_W'(byte_value_i);
              if (lz == 3'd0) begin
                phase_d = PH_SIZE;
              end else begin
                vrem_d = {1'b0, lz};
              end
            end
          end else begin
            id_d   = {id_q[eehw_pkg::ID_W-9:0], byte_value_i};
            vrem_d = vrem_q - 4'd1;
            if (vrem_q == 4'd1) begin
              phase_d = PH_SIZE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_ID;
      vrem_q   <= '0;
      id_q     <= '0;
      size_q   <= '0;
      offset_q <= '0;
      skip_q   <= '0;
      depth_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      vrem_q   <= vrem_d;
      id_q     <= id_d;
      size_q   <= size_d;
      offset_q <= offset_d;
      skip_q   <= skip_d;
      depth_q  <= depth_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (le_we) begin
      level_end_q[IW'(depth_q)] <= end_val;
    end
  end

  // Output register plus one skid entry.
  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (!out_valid_q || out_fire) begin
        out_valid_q <= res_valid;
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_fire) begin
      out_q <= res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign element_id_o     = out_q.element_id;
  assign element_size_o   = out_q.element_size;
  assign nest_depth_o     = out_q.nest_depth;
  assign payload_offset_o = out_q.payload_offset;
  assign is_master_o      = out_q.is_master;
  assign status_o         = out_q.status;

  // The skid entry is only ever filled behind a waiting output register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output register valid");

  // Once halted, the walker stays halted until reset.
  a_halt_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted state released without reset");

  // An error event always halts the walker.
  a_error_halts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (res.status != eehw_pkg::ST_OK)) |=> halted_q)
    else $error("error event without halt");

  // The number of open levels never exceeds the level-end storage.
  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MD))
    else $error("nesting depth beyond storage");

endmodule
